>>> hw/rtl/pwci_pkg.sv
// ----------------------------------------------------------------------------
// pwci_pkg
// Shared types, constants and saturating helpers of the wall collision
// and leapfrog integrator (signed Q23.40 fixed point).
// ----------------------------------------------------------------------------
package pwci_pkg;

  localparam int WordW    = 64;
  localparam int FracBits = 40;
  localparam int CellIdxW = 10;
  localparam int CellCntW = 11;
  localparam int MaxCells = 1024;

  localparam logic signed [WordW-1:0] SatMax = {1'b0, {(WordW-1){1'b1}}};
  localparam logic signed [WordW-1:0] SatMin = {1'b1, {(WordW-1){1'b0}}};

  typedef logic signed [WordW-1:0] fix_t;

  typedef enum logic [2:0] {
    CfgTimeStep,
    CfgParticleSize,
    CfgWallStiffness,
    CfgWallDamping,
    CfgContactThreshold,
    CfgAxisMin,
    CfgAxisMax,
    CfgCellCount
  } cfg_reg_e;

  typedef struct packed {
    logic signed [WordW-1:0] position;
    logic signed [WordW-1:0] half_velocity;
    logic signed [WordW-1:0] velocity;
    logic signed [WordW-1:0] acceleration;
    logic [CellIdxW-1:0]     cell_index;
  } in_beat_t;

  typedef struct packed {
    logic signed [WordW-1:0] new_position;
    logic signed [WordW-1:0] new_velocity;
    logic signed [WordW-1:0] new_half_velocity;
    logic signed [WordW-1:0] new_acceleration;
    logic                    reflected;
  } out_beat_t;

  function automatic fix_t sat_add(fix_t a, fix_t b);
    logic signed [WordW:0] s;
    s = {a[WordW-1], a} + {b[WordW-1], b};
    if (s[WordW] != s[WordW-1]) begin
      return s[WordW] ? SatMin : SatMax;
    end
    return s[WordW-1:0];
  endfunction

  function automatic fix_t sat_sub(fix_t a, fix_t b);
    logic signed [WordW:0] s;
    s = {a[WordW-1], a} - {b[WordW-1], b};
    if (s[WordW] != s[WordW-1]) begin
      return s[WordW] ? SatMin : SatMax;
    end
    return s[WordW-1:0];
  endfunction

  function automatic fix_t sat_neg(fix_t a);
    return (a == SatMin) ? SatMax : -a;
  endfunction

endpackage

>>> hw/rtl/pwci_stream_if.sv
// ----------------------------------------------------------------------------
// pwci_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface pwci_stream_if #(
  parameter type data_t = logic
) ();

  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

>>> hw/rtl/pwci_fxmul.sv
// ----------------------------------------------------------------------------
// pwci_fxmul
// Four-stage Q23.40 multiplier: sign/magnitude split, 32x32 partial
// products, 128-bit recombine, floor rounding and saturation.
// ----------------------------------------------------------------------------
module pwci_fxmul import pwci_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  fix_t a_i,
  input  fix_t b_i,
  output fix_t p_o
);

  localparam int HalfW = WordW / 2;

  logic [WordW-1:0] ua_q, ub_q;
  logic             neg1_q, neg2_q, neg3_q;
  logic [WordW-1:0] p00_q, p01_q, p10_q, p11_q;
  logic [WordW-1:0] q3_q;
  logic             over3_q, rem3_q;
  fix_t             p_q;

  logic [WordW-1:0] ua_d, ub_d;
  logic [HalfW+1:0] mid;
  logic [WordW-1:0] hi, lo;
  logic [WordW-1:0] q_d;
  logic             over_d, rem_d;
  fix_t             p_d;

  always_comb begin
    ua_d = a_i[WordW-1] ? (~a_i + 1'b1) : a_i;
    ub_d = b_i[WordW-1] ? (~b_i + 1'b1) : b_i;
  end

  always_comb begin
    mid = (HalfW+2)'(p00_q[WordW-1:HalfW]) + (HalfW+2)'(p01_q[HalfW-1:0])
        + (HalfW+2)'(p10_q[HalfW-1:0]);
    lo  = {mid[HalfW-1:0], p00_q[HalfW-1:0]};
    hi  = p11_q + WordW'(p01_q[WordW-1:HalfW]) + WordW'(p10_q[WordW-1:HalfW])
        + WordW'(mid[HalfW+1:HalfW]);
    q_d    = {hi[FracBits-1:0], lo[WordW-1:FracBits]};
    over_d = |hi[WordW-1:FracBits];
    rem_d  = |lo[FracBits-1:0];
  end

  always_comb begin
    if (!neg3_q) begin
      p_d = (over3_q || q3_q[WordW-1]) ? SatMax : fix_t'(q3_q);
    end else begin
      p_d = (over3_q || q3_q[WordW-1]) ? SatMin : fix_t'(~(q3_q + WordW'(rem3_q)) + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q    <= ua_d;
      ub_q    <= ub_d;
      neg1_q  <= a_i[WordW-1] ^ b_i[WordW-1];
      p00_q   <= ua_q[HalfW-1:0] * ub_q[HalfW-1:0];
      p01_q   <= ua_q[HalfW-1:0] * ub_q[WordW-1:HalfW];
      p10_q   <= ua_q[WordW-1:HalfW] * ub_q[HalfW-1:0];
      p11_q   <= ua_q[WordW-1:HalfW] * ub_q[WordW-1:HalfW];
      neg2_q  <= neg1_q;
      q3_q    <= q_d;
      over3_q <= over_d;
      rem3_q  <= rem_d;
      neg3_q  <= neg2_q;
      p_q     <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

>>> hw/rtl/particle_wall_collision_integrator_top.sv
// ----------------------------------------------------------------------------
// particle_wall_collision_integrator_top
// Wall collision force and leapfrog step for one axis of one particle.
// ----------------------------------------------------------------------------
// One beat is one axis of one particle; a new beat is taken every cycle
// while the output is not stalled. Three chained four-stage 64x64
// fixed-point multipliers (step products, wall spring force, acceleration
// products) plus registered saturating adds make up the pipeline. A stall
// on the output holds the whole pipeline and drops in_i.ready in the same
// cycle. Configuration must be written through the cfg port only while no
// beat is in flight; the block does not enforce this. There is no read-back.
module particle_wall_collision_integrator_top import pwci_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  cfg_reg_e         cfg_idx_i,
  input  logic [WordW-1:0] cfg_data_i,
  pwci_stream_if.sink      in_i,
  pwci_stream_if.source    out_o
);

  localparam int Latency = 20;
  localparam int MulLat  = 4;

  typedef struct packed {
    fix_t p;
    fix_t h;
    fix_t a;
    logic low;
    logic high;
  } head_t;

  typedef struct packed {
    fix_t pred;
    fix_t h;
    fix_t a;
    fix_t dtdt;
    fix_t dampv;
    logic low;
    logic high;
  } side_t;

  typedef struct packed {
    fix_t p1;
    fix_t v1;
    fix_t h1;
    fix_t a;
    logic low;
    logic high;
  } step_t;

  // configuration
  logic [WordW-2:0]    time_step_q, particle_size_q, wall_stiffness_q, wall_damping_q;
  fix_t                contact_threshold_q, axis_min_q, axis_max_q;
  logic [CellCntW-1:0] cell_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q         <= '0;
      particle_size_q     <= '0;
      wall_stiffness_q    <= '0;
      wall_damping_q      <= '0;
      contact_threshold_q <= '0;
      axis_min_q          <= '0;
      axis_max_q          <= '0;
      cell_count_q        <= CellCntW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTimeStep:         time_step_q         <= cfg_data_i[WordW-2:0];
        CfgParticleSize:     particle_size_q     <= cfg_data_i[WordW-2:0];
        CfgWallStiffness:    wall_stiffness_q    <= cfg_data_i[WordW-2:0];
        CfgWallDamping:      wall_damping_q      <= cfg_data_i[WordW-2:0];
        CfgContactThreshold: contact_threshold_q <= cfg_data_i;
        CfgAxisMin:          axis_min_q          <= cfg_data_i;
        CfgAxisMax:          axis_max_q          <= cfg_data_i;
        CfgCellCount:        cell_count_q        <= cfg_data_i[CellCntW-1:0];
      endcase
    end
  end

  fix_t dt, size_s, stiff_s, damp_s;
  assign dt      = {1'b0, time_step_q};
  assign size_s  = {1'b0, particle_size_q};
  assign stiff_s = {1'b0, wall_stiffness_q};
  assign damp_s  = {1'b0, wall_damping_q};

  // pipeline control
  logic [Latency-1:0] vld_q;
  logic               en;

  assign en          = !vld_q[Latency-1] || out_o.ready;
  assign in_i.ready  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Latency-2:0], in_i.valid};
    end
  end

  // edge cell detection
  logic [CellCntW-1:0] n_cells;
  logic                low_d, high_d;

  always_comb begin
    n_cells = (cell_count_q > CellCntW'(MaxCells)) ? CellCntW'(MaxCells) : cell_count_q;
    low_d   = (in_i.data.cell_index == '0);
    high_d  = (n_cells != '0) &&
              ({1'b0, in_i.data.cell_index} == (n_cells - CellCntW'(1)));
  end

  // multipliers
  fix_t hdt, dtdt, dampv, kd, adt, adtdt;
  fix_t d7_q;
  side_t sb13_q;

  pwci_fxmul u_mul_hdt (
    .clk_i (clk_i), .en_i (en), .a_i (in_i.data.half_velocity), .b_i (dt), .p_o (hdt)
  );
  pwci_fxmul u_mul_dtdt (
    .clk_i (clk_i), .en_i (en), .a_i (dt), .b_i (dt), .p_o (dtdt)
  );
  pwci_fxmul u_mul_dampv (
    .clk_i (clk_i), .en_i (en), .a_i (damp_s), .b_i (in_i.data.velocity), .p_o (dampv)
  );
  pwci_fxmul u_mul_kd (
    .clk_i (clk_i), .en_i (en), .a_i (stiff_s), .b_i (d7_q), .p_o (kd)
  );
  pwci_fxmul u_mul_adt (
    .clk_i (clk_i), .en_i (en), .a_i (sb13_q.a), .b_i (dt), .p_o (adt)
  );
  pwci_fxmul u_mul_adtdt (
    .clk_i (clk_i), .en_i (en), .a_i (sb13_q.a), .b_i (sb13_q.dtdt), .p_o (adtdt)
  );

  // datapath registers
  head_t     sa_q [MulLat];
  side_t     sb5_q, sb6_q, sb7_q, sb12_q;
  side_t     sc_q [MulLat];
  side_t     sd_q [MulLat];
  logic      fon_q [MulLat];
  logic      fon12_q;
  fix_t      inner6_q, f12_q, gap19_q;
  step_t     r18_q, r19_q;
  out_beat_t out_q;

  fix_t      pred_d, inner_d, d_d, f_d, anew_d, gap_d;
  logic      fon_d, mirror_d;
  side_t     sb13_d;
  step_t     r18_d;
  out_beat_t out_d;

  always_comb begin
    pred_d  = sat_add(sa_q[MulLat-1].p, hdt);
    inner_d = sb5_q.low ? sat_sub(sb5_q.pred, axis_min_q) : sat_sub(axis_max_q, sb5_q.pred);
    d_d     = sat_sub(size_s, inner6_q);
    fon_d   = (sb7_q.low || sb7_q.high) && (d7_q > contact_threshold_q);
    f_d     = sc_q[MulLat-1].low ? sat_sub(kd, sc_q[MulLat-1].dampv)
                                 : sat_add(kd, sc_q[MulLat-1].dampv);
    if (!fon12_q) begin
      anew_d = sb12_q.a;
    end else if (sb12_q.low) begin
      anew_d = sat_add(sb12_q.a, f12_q);
    end else begin
      anew_d = sat_sub(sb12_q.a, f12_q);
    end
    sb13_d   = sb12_q;
    sb13_d.a = anew_d;
  end

  always_comb begin
    r18_d.p1   = sat_add(sd_q[MulLat-1].pred, adtdt);
    r18_d.v1   = sat_add(sd_q[MulLat-1].h, adt >>> 1);
    r18_d.h1   = sat_add(sd_q[MulLat-1].h, adt);
    r18_d.a    = sd_q[MulLat-1].a;
    r18_d.low  = sd_q[MulLat-1].low;
    r18_d.high = sd_q[MulLat-1].high;
    gap_d      = r18_q.high ? sat_sub(axis_max_q, r18_q.p1) : sat_sub(r18_q.p1, axis_min_q);
  end

  always_comb begin
    mirror_d = (r19_q.low || r19_q.high) && gap19_q[WordW-1];
    out_d.new_acceleration = r19_q.a;
    out_d.reflected        = mirror_d;
    if (mirror_d) begin
      out_d.new_position      = r19_q.high ? sat_add(axis_max_q, gap19_q)
                                           : sat_sub(axis_min_q, gap19_q);
      out_d.new_velocity      = sat_neg(r19_q.v1);
      out_d.new_half_velocity = sat_neg(r19_q.h1);
    end else begin
      out_d.new_position      = r19_q.p1;
      out_d.new_velocity      = r19_q.v1;
      out_d.new_half_velocity = r19_q.h1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q[0] <= '{p: in_i.data.position, h: in_i.data.half_velocity,
                   a: in_i.data.acceleration, low: low_d, high: high_d};
      for (int k = 1; k < MulLat; k++) begin
        sa_q[k]  <= sa_q[k-1];
        sc_q[k]  <= sc_q[k-1];
        sd_q[k]  <= sd_q[k-1];
        fon_q[k] <= fon_q[k-1];
      end
      sb5_q    <= '{pred: pred_d, h: sa_q[MulLat-1].h, a: sa_q[MulLat-1].a,
                    dtdt: dtdt, dampv: dampv,
                    low: sa_q[MulLat-1].low, high: sa_q[MulLat-1].high};
      sb6_q    <= sb5_q;
      inner6_q <= inner_d;
      sb7_q    <= sb6_q;
      d7_q     <= d_d;
      sc_q[0]  <= sb7_q;
      fon_q[0] <= fon_d;
      sb12_q   <= sc_q[MulLat-1];
      f12_q    <= f_d;
      fon12_q  <= fon_q[MulLat-1];
      sb13_q   <= sb13_d;
      sd_q[0]  <= sb13_q;
      r18_q    <= r18_d;
      r19_q    <= r18_q;
      gap19_q  <= gap_d;
      out_q    <= out_d;
    end
  end

  assign out_o.valid = vld_q[Latency-1];
  assign out_o.data  = out_q;

  // assertions
  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input taken while result is stalled");

  a_stall_holds_valids : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valids moved during stall");

  a_low_mirror_inside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[Latency-2] && mirror_d && !r19_q.high
    |=> out_q.new_position >= axis_min_q)
    else $error("low wall mirror left position below bound");

  a_high_mirror_inside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[Latency-2] && mirror_d && r19_q.high
    |=> out_q.new_position <= axis_max_q)
    else $error("high wall mirror left position above bound");

endmodule

>>> tb/tb_particle_wall_collision_integrator_top.sv
// ----------------------------------------------------------------------------
// tb_particle_wall_collision_integrator_top
// Self-checking bench for the wall collision and leapfrog step: a bursty
// driver feeds axis beats, a clocked monitor predicts every result in
// Q23.40 fixed point and checks each output beat in order, over a series
// of register settings from reset values to full-scale extremes.
// ----------------------------------------------------------------------------
module tb_particle_wall_collision_integrator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pwci_pkg::*;

  localparam int   PipeDepth        = 20;
  localparam int   NumSettings      = 9;
  localparam int   RandomPerSetting = 105;
  localparam int   CycleLimit       = 400000;
  localparam fix_t One              = fix_t'(64'd1 << FracBits);

  logic           clk_i      = 1'b0;
  logic           rst_ni     = 1'b0;
  logic           cfg_we_i   = 1'b0;
  cfg_reg_e       cfg_idx_i  = CfgTimeStep;
  logic [WordW-1:0] cfg_data_i = '0;

  logic      drv_valid  = 1'b0;
  in_beat_t  drv_data   = '0;
  logic      take_ready = 1'b0;

  pwci_stream_if #(.data_t(in_beat_t))  in_ch  ();
  pwci_stream_if #(.data_t(out_beat_t)) out_ch ();

  assign in_ch.valid  = drv_valid;
  assign in_ch.data   = drv_data;
  assign out_ch.ready = take_ready;

  particle_wall_collision_integrator_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  logic [63:0] reg_copy [8] = '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd1};

  in_beat_t  pending_axes [$];
  out_beat_t predicted_steps [$];

  bit in_took     = 1'b0;
  bit steady_send = 1'b1;
  int sink_mode   = 0;
  int burst_left  = 8;
  int gap_left    = 0;
  int stall_tick  = 0;
  int stall_left  = 0;
  int cycle_count = 0;
  int errors      = 0;
  int beats_checked = 0;
  int mirrored    = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // saturating Q23.40 arithmetic
  function automatic fix_t add_q(fix_t a, fix_t b);
    fix_t r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) return a[63] ? SatMin : SatMax;
    return r;
  endfunction

  function automatic fix_t sub_q(fix_t a, fix_t b);
    fix_t r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) return a[63] ? SatMin : SatMax;
    return r;
  endfunction

  function automatic fix_t neg_q(fix_t a);
    if (a[63] && a[62:0] == '0) return SatMax;
    return -a;
  endfunction

  function automatic fix_t mul_q(fix_t a, fix_t b);
    logic signed [127:0] wa, wb, prod;
    wa = a;
    wb = b;
    prod = (wa * wb) >>> FracBits;
    if (prod[127:63] != {65{prod[127]}}) return prod[127] ? SatMin : SatMax;
    return prod[63:0];
  endfunction

  function automatic int cells_on_axis();
    logic [CellCntW-1:0] n;
    n = reg_copy[CfgCellCount][CellCntW-1:0];
    if (n > CellCntW'(MaxCells)) n = CellCntW'(MaxCells);
    return int'(n);
  endfunction

  function automatic out_beat_t step_axis(in_beat_t b);
    out_beat_t r;
    fix_t dt, size, k, damp, thr, amin, amax;
    fix_t acc, hdt, pred, d, adt, p1, v1, h1, gap;
    int   n;
    logic low, high;
    dt   = fix_t'({1'b0, reg_copy[CfgTimeStep][62:0]});
    size = fix_t'({1'b0, reg_copy[CfgParticleSize][62:0]});
    k    = fix_t'({1'b0, reg_copy[CfgWallStiffness][62:0]});
    damp = fix_t'({1'b0, reg_copy[CfgWallDamping][62:0]});
    thr  = fix_t'(reg_copy[CfgContactThreshold]);
    amin = fix_t'(reg_copy[CfgAxisMin]);
    amax = fix_t'(reg_copy[CfgAxisMax]);
    n    = cells_on_axis();
    low  = (b.cell_index == '0);
    high = (n != 0) && (int'(b.cell_index) == n - 1);
    acc  = b.acceleration;
    hdt  = mul_q(b.half_velocity, dt);
    pred = add_q(b.position, hdt);
    if (low) begin
      d = sub_q(size, sub_q(pred, amin));
      if (d > thr) acc = add_q(acc, sub_q(mul_q(k, d), mul_q(damp, b.velocity)));
    end else if (high) begin
      d = sub_q(size, sub_q(amax, pred));
      if (d > thr) acc = sub_q(acc, add_q(mul_q(k, d), mul_q(damp, b.velocity)));
    end
    adt = mul_q(acc, dt);
    p1  = add_q(add_q(b.position, hdt), mul_q(acc, mul_q(dt, dt)));
    v1  = add_q(b.half_velocity, adt >>> 1);
    h1  = add_q(b.half_velocity, adt);
    r.reflected = 1'b0;
    if (low || high) begin
      gap = high ? sub_q(amax, p1) : sub_q(p1, amin);
      if (gap < 0) begin
        p1 = high ? add_q(amax, gap) : sub_q(amin, gap);
        v1 = neg_q(v1);
        h1 = neg_q(h1);
        r.reflected = 1'b1;
      end
    end
    r.new_position      = p1;
    r.new_velocity      = v1;
    r.new_half_velocity = h1;
    r.new_acceleration  = acc;
    return r;
  endfunction

  // random magnitude on a random scale, random sign
  function automatic fix_t rand_scaled();
    logic [63:0] r;
    r = {$urandom, $urandom} >> $urandom_range(1, 63);
    return $urandom_range(0, 1) ? -fix_t'(r) : fix_t'(r);
  endfunction

  function automatic fix_t pick_extreme();
    case ($urandom_range(0, 4))
      0:       return SatMax;
      1:       return SatMin;
      2:       return fix_t'(0);
      3:       return fix_t'(-1);
      default: return fix_t'(1);
    endcase
  endfunction

  function automatic in_beat_t random_axis();
    in_beat_t b;
    fix_t     lo, hi;
    int       n, kind;
    lo = fix_t'(reg_copy[CfgAxisMin]);
    hi = fix_t'(reg_copy[CfgAxisMax]);
    n  = cells_on_axis();
    kind = $urandom_range(0, 9);
    b.half_velocity = rand_scaled();
    b.velocity      = rand_scaled();
    b.acceleration  = rand_scaled();
    if (kind < 7) begin
      case ($urandom_range(0, 3))
        0: begin
          b.cell_index = '0;
          b.position   = add_q(lo, rand_scaled());
        end
        1: begin
          b.cell_index = (n == 0) ? CellIdxW'($urandom_range(0, 1023)) : CellIdxW'(n - 1);
          b.position   = add_q(hi, rand_scaled());
        end
        2: begin
          b.cell_index = (n > 2) ? CellIdxW'($urandom_range(1, n - 2))
                                 : CellIdxW'($urandom_range(0, 1023));
          b.position   = add_q(add_q(lo, sub_q(hi, lo) >>> 1), rand_scaled());
        end
        default: begin
          b.cell_index = (n < 1024) ? CellIdxW'($urandom_range(n, 1023))
                                    : CellIdxW'($urandom_range(0, 1023));
          b.position   = rand_scaled();
        end
      endcase
    end else if (kind < 9) begin
      b.position      = {$urandom, $urandom};
      b.half_velocity = {$urandom, $urandom};
      b.velocity      = {$urandom, $urandom};
      b.acceleration  = {$urandom, $urandom};
      b.cell_index    = CellIdxW'($urandom);
    end else begin
      b.position      = pick_extreme();
      b.half_velocity = pick_extreme();
      b.velocity      = pick_extreme();
      b.acceleration  = pick_extreme();
      b.cell_index    = $urandom_range(0, 1) ? '0 : '1;
    end
    return b;
  endfunction

  task automatic queue_axis(fix_t p, fix_t h, fix_t v, fix_t a, logic [CellIdxW-1:0] c);
    in_beat_t b;
    b.position      = p;
    b.half_velocity = h;
    b.velocity      = v;
    b.acceleration  = a;
    b.cell_index    = c;
    pending_axes = {pending_axes, b};
  endtask

  task automatic load_setting(input int ph);
    logic [63:0] vals [8];
    fix_t        swap;
    cfg_reg_e    r;
    case (ph)
      0: vals = '{64'd1 << 30, 64'd1 << 36, 64'd1 << 50, 64'd1 << 42, 64'd0,
                  64'(-(One * 5)), 64'(One * 5), 64'd16};
      1: vals = '{64'd1 << 34, 64'd1 << 38, 64'd1 << 46, 64'd1 << 40, 64'(-(64'sd1 << 30)),
                  64'd0, 64'(One * 4), 64'd1};
      2: vals = '{64'd1 << 32, 64'd1 << 37, 64'd1 << 48, 64'd1 << 41, 64'd1 << 20,
                  64'(-One), 64'(One * 3), 64'd0};
      // top bits set on the time step, particle size and cell count registers to exercise the width masks
      3: vals = '{64'h8000_0000_4000_0000, 64'h8000_0010_0000_0000, 64'd1 << 52,
                  64'd1 << 44, 64'd0, 64'(-(One * 100)), 64'(One * 100), '1};
      4: vals = '{64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                  64'h7FFF_FFFF_FFFF_FFFF, 64'(SatMin), 64'(SatMin), 64'(SatMax), 64'd1024};
      5: vals = '{64'd0, 64'd0, 64'd0, 64'd0, 64'(SatMax), 64'd0, 64'd0, 64'd2};
      6: vals = '{64'd1, 64'd1 << 39, 64'd1 << 60, 64'd1 << 58, '1,
                  64'(-(One * 1024)), 64'(-(One * 256)), 64'd1023};
      default: begin
        vals[CfgTimeStep]      = ({$urandom, $urandom} >> $urandom_range(14, 40))
                                 | {1'($urandom_range(0, 1)), 63'd0};
        vals[CfgParticleSize]  = ({$urandom, $urandom} >> $urandom_range(16, 50))
                                 | {1'($urandom_range(0, 1)), 63'd0};
        vals[CfgWallStiffness] = ({$urandom, $urandom} >> $urandom_range(2, 30))
                                 | {1'($urandom_range(0, 1)), 63'd0};
        vals[CfgWallDamping]   = ({$urandom, $urandom} >> $urandom_range(8, 40))
                                 | {1'($urandom_range(0, 1)), 63'd0};
        vals[CfgContactThreshold] = rand_scaled();
        vals[CfgAxisMin]       = rand_scaled();
        vals[CfgAxisMax]       = rand_scaled();
        if (fix_t'(vals[CfgAxisMin]) > fix_t'(vals[CfgAxisMax])) begin
          swap = vals[CfgAxisMin];
          vals[CfgAxisMin] = vals[CfgAxisMax];
          vals[CfgAxisMax] = swap;
        end
        vals[CfgCellCount]     = 64'($urandom_range(0, 2047));
      end
    endcase
    r = r.first();
    repeat (8) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= r;
      cfg_data_i <= vals[r];
      reg_copy[r] = vals[r];
      r = r.next();
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every queued beat is taken and every result has come back
  task automatic settle();
    while (pending_axes.size() != 0 || drv_valid || predicted_steps.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2 * PipeDepth) @(posedge clk_i);
  endtask

  // source side: bursts of beats with random gaps, none while steady_send is set
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else if (!(drv_valid && !in_took)) begin
      if (drv_valid) begin
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = steady_send ? 0 : $urandom_range(1, 8);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        drv_valid <= 1'b0;
      end else if (pending_axes.size() != 0) begin
        drv_valid <= 1'b1;
        drv_data  <= pending_axes.pop_front();
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // sink side stall patterns
  always @(negedge clk_i) begin
    stall_tick++;
    case (sink_mode)
      0: take_ready <= 1'b1;
      1: take_ready <= ($urandom_range(0, 3) != 0);
      2: take_ready <= ((stall_tick % 9) < 5);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          take_ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_left = $urandom_range(5, 30);
          take_ready <= 1'b0;
        end else begin
          take_ready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    in_took <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      predicted_steps = {predicted_steps, step_axis(in_ch.data)};
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (predicted_steps.size() == 0) begin
        errors++;
        $display("%0t: unexpected output beat, actual %h", $time, out_ch.data);
      end else begin
        want = predicted_steps.pop_front();
        beats_checked++;
        if (want.reflected) mirrored++;
        if (out_ch.data !== want) begin
          errors++;
          $display("%0t: beat %0d mismatch", $time, beats_checked);
          $display("  expected pos %h vel %h half %h acc %h mirror %b", want.new_position,
                   want.new_velocity, want.new_half_velocity, want.new_acceleration,
                   want.reflected);
          $display("  actual   pos %h vel %h half %h acc %h mirror %b",
                   out_ch.data.new_position, out_ch.data.new_velocity,
                   out_ch.data.new_half_velocity, out_ch.data.new_acceleration,
                   out_ch.data.reflected);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: cycle limit reached with %0d results outstanding", $time,
               predicted_steps.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset register values: one cell, so cell 0 is both walls
    queue_axis(One, One, fix_t'(0), One, '0);
    queue_axis(-One, -One, One, fix_t'(0), '0);
    queue_axis(SatMin, fix_t'(0), fix_t'(0), fix_t'(0), '0);
    queue_axis(One, fix_t'(0), fix_t'(0), fix_t'(0), CellIdxW'(5));
    settle();

    for (int ph = 0; ph < NumSettings; ph++) begin
      steady_send = (ph % 4 == 0);
      sink_mode   = ph % 4;
      load_setting(ph);
      if (ph == 0) begin
        queue_axis(One, One >>> 1, One >>> 1, One * 2, CellIdxW'(7));
        queue_axis(-(One * 5) - (One >>> 10), -(One * 3), One, fix_t'(0), '0);
        queue_axis(-(One * 5) + (One >>> 5), fix_t'(0), -One, fix_t'(0), '0);
        queue_axis(-(One * 3), One, fix_t'(0), One, '0);
        queue_axis(One * 5 + (One >>> 7), One * 3, fix_t'(0), fix_t'(0), CellIdxW'(15));
        queue_axis(One * 5 - (One >>> 5), fix_t'(0), -One, -One, CellIdxW'(15));
        queue_axis(One * 6, One, One, One, CellIdxW'(16));
        queue_axis(-(One * 6), -One, fix_t'(0), fix_t'(0), '1);
        queue_axis(SatMax, SatMax, SatMax, SatMax, CellIdxW'(15));
        queue_axis(SatMin, SatMin, SatMin, SatMin, '0);
        queue_axis(SatMin, SatMin, SatMin, SatMin, CellIdxW'(15));
        queue_axis(SatMax, SatMax, SatMax, SatMax, '0);
        queue_axis(fix_t'(-1), fix_t'(-1), fix_t'(-1), fix_t'(-1), '0);
        queue_axis(fix_t'(0), SatMax, SatMin, fix_t'(0), CellIdxW'(15));
        queue_axis(fix_t'(0), SatMin, SatMax, SatMax, '0);
        queue_axis(-(One * 5), fix_t'(0), fix_t'(0), fix_t'(0), '0);
        queue_axis(One * 5, fix_t'(0), fix_t'(0), fix_t'(0), CellIdxW'(15));
        queue_axis(fix_t'(0), fix_t'(0), fix_t'(0), SatMin, CellIdxW'(3));
      end
      repeat (RandomPerSetting) pending_axes = {pending_axes, random_axis()};
      settle();
    end

    $display("covered %0d beats over %0d register settings, %0d mirrored at a wall",
             beats_checked, NumSettings + 1, mirrored);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/pwci_pkg.sv
hw/rtl/pwci_stream_if.sv
hw/rtl/pwci_fxmul.sv
hw/rtl/particle_wall_collision_integrator_top.sv
tb/tb_particle_wall_collision_integrator_top.sv
